@@ rtl/block_average_downscaler_unit_defines.svh @@
// Assertion macros shared by the downscaler RTL.
`ifndef BLOCK_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH
`define BLOCK_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAVG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAVG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bavg_pkg.sv @@
`default_nettype none
package bavg_pkg;

   localparam int DEF_MAX_COLS   = 2048;
   localparam int DEF_MAX_FACTOR = 16;
   localparam int ROW_LIMIT      = 2048;

   localparam int PIXEL_W   = 8;
   localparam int FACTOR_W  = 5;
   localparam int DIM_W     = 12;
   localparam int ROW_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd2;

   localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd1;
   localparam logic [DIM_W-1:0]    RST_COLS   = 12'd640;
   localparam logic [DIM_W-1:0]    RST_ROWS   = 12'd480;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic capture;    // latch pixel and address, read block sum
      logic accum;      // add pixel and write block sum back
      logic first;      // first pixel of its block: sum starts fresh
      logic div_start;  // block complete: start the divider
      logic out_load;   // load the output register
      logic out_last;   // last block of the image
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/block_average_downscaler_unit.sv @@
// A block-ending pixel's average passes through the capture registers, the ACCUM state, the
// bit-serial divider in the DIVIDE state (one quotient bit a cycle), then the output register.
// A pixel outside any full block does not stall the next; one inside a block stalls intake
// to read, then add and write its sum; a block-ending one also waits for divider and output.
// Reset: synchronous, active high; clears counters and control, registers to 1/640/480.
// The block-sum memory is not cleared: each entry is written by its block's first pixel.
`default_nettype none
module block_average_downscaler_unit #(
   parameter int MAX_COLS   = bavg_pkg::DEF_MAX_COLS,
   parameter int MAX_FACTOR = bavg_pkg::DEF_MAX_FACTOR
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [bavg_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [bavg_pkg::PIXEL_W-1:0]          rsp_average,
   output logic                                  rsp_image_done,
   input  wire logic                             csr_write,
   input  wire logic [bavg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bavg_pkg::DIM_W-1:0]       csr_data
);
   import bavg_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int EF_W  = $clog2(MAX_FACTOR + 1);

   cmd_type          cmd;
   status_type       status;
   logic [COL_W-1:0] blk_addr;
   logic [EF_W-1:0]  blk_factor;

   bavg_ctrl #(
      .MAX_COLS   (MAX_COLS),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .status     (status),
      .cmd        (cmd),
      .blk_addr   (blk_addr),
      .blk_factor (blk_factor)
   );

   bavg_dp #(
      .MAX_COLS   (MAX_COLS),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .blk_addr       (blk_addr),
      .blk_factor     (blk_factor),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_average    (rsp_average),
      .rsp_image_done (rsp_image_done)
   );

endmodule
`default_nettype wire

@@ rtl/bavg_div.sv @@
`default_nettype none
`include "block_average_downscaler_unit_defines.svh"
module bavg_div #(
   parameter int N_W = 16,
   parameter int D_W = 10
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] dividend,
   input  wire logic [D_W-1:0] divisor,
   output logic                busy,
   output logic [N_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(N_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   dvsr_ff, dvsr_in;
   logic [D_W:0]     rem_sh;
   logic             ge;

   // One quotient bit per cycle, dividend shifted out MSB first.
   assign rem_sh = {rem_ff, quo_ff[N_W-1]};
   assign ge     = rem_sh >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(N_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N_W-2:0], ge};
         rem_in = ge ? D_W'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[D_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   `BAVG_ASSERT_NEXT(a_div_starts, start, busy_ff && cnt_ff == CNT_W'(N_W), "divider did not start")
   `BAVG_ASSERT_SAME(a_div_cnt_live, busy_ff, cnt_ff != '0, "divider busy with zero count")
   `BAVG_ASSERT_SAME(a_div_rem_bound, busy_ff && dvsr_ff != '0, rem_ff < dvsr_ff, "remainder out of range")

endmodule
`default_nettype wire

@@ rtl/bavg_ctrl.sv @@
`default_nettype none
`include "block_average_downscaler_unit_defines.svh"
module bavg_ctrl #(
   parameter int MAX_COLS   = bavg_pkg::DEF_MAX_COLS,
   parameter int MAX_FACTOR = bavg_pkg::DEF_MAX_FACTOR
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               csr_write,
   input  wire logic [bavg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bavg_pkg::DIM_W-1:0]         csr_data,
   input  wire bavg_pkg::status_type               status,
   output bavg_pkg::cmd_type                       cmd,
   output logic [$clog2(MAX_COLS)-1:0]             blk_addr,
   output logic [$clog2(MAX_FACTOR+1)-1:0]         blk_factor
);
   import bavg_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int CNT_W = $clog2(MAX_COLS + 1);
   localparam int EF_W  = $clog2(MAX_FACTOR + 1);
   localparam int CIB_W = $clog2(MAX_FACTOR);
   localparam int XW    = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 2;

   state_type             state_ff, state_in;
   logic [FACTOR_W-1:0]   factor_ff, factor_in;
   logic [DIM_W-1:0]      cols_ff, cols_in;
   logic [DIM_W-1:0]      rows_ff, rows_in;
   logic [COL_W-1:0]      col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]      row_pos_ff, row_pos_in;
   logic [CIB_W-1:0]      cib_ff, cib_in;
   logic [CIB_W-1:0]      rib_ff, rib_in;
   logic [COL_W-1:0]      bcol_ff, bcol_in;
   logic                  first_ff, last_ff, img_ff;

   logic [EF_W-1:0]       eff_f;
   logic [CNT_W-1:0]      eff_cols;
   logic [DIM_W-1:0]      eff_rows;
   logic [CNT_W-1:0]      col_next;
   logic [DIM_W-1:0]      row_next;
   logic [EF_W-1:0]       cib_next;
   logic [EF_W-1:0]       rib_next;
   logic                  accept;
   logic                  restart;
   logic                  col_fit, row_fit, in_block;
   logic                  blk_first, blk_last, img_last;

   // Effective register values with out-of-range codes folded in.
   always_comb begin
      if (factor_ff == '0) begin
         eff_f = EF_W'(1);
      end else if (32'(factor_ff) > 32'(MAX_FACTOR)) begin
         eff_f = EF_W'(MAX_FACTOR);
      end else begin
         eff_f = EF_W'(factor_ff);
      end
      if (cols_ff == '0) begin
         eff_cols = CNT_W'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         eff_cols = CNT_W'(MAX_COLS);
      end else begin
         eff_cols = CNT_W'(cols_ff);
      end
      if (rows_ff == '0) begin
         eff_rows = DIM_W'(1);
      end else if (32'(rows_ff) > 32'(ROW_LIMIT)) begin
         eff_rows = DIM_W'(ROW_LIMIT);
      end else begin
         eff_rows = rows_ff;
      end
   end

   assign accept  = req_valid && !req_stall;
   assign restart = csr_write &&
                    (csr_index == CSR_FACTOR || csr_index == CSR_COLS ||
                     csr_index == CSR_ROWS);

   // A pixel counts only if its whole block lies inside the image.
   assign col_fit = XW'(col_pos_ff) - XW'(cib_ff) + XW'(eff_f) <= XW'(eff_cols);
   assign row_fit = XW'(row_pos_ff) - XW'(rib_ff) + XW'(eff_f) <= XW'(eff_rows);
   assign in_block  = col_fit && row_fit;
   assign blk_first = (cib_ff == '0) && (rib_ff == '0);
   assign blk_last  = (EF_W'(cib_ff) + 1'b1 == eff_f) && (EF_W'(rib_ff) + 1'b1 == eff_f);
   assign img_last  = (XW'(col_pos_ff) + XW'(1) + XW'(eff_f) > XW'(eff_cols)) &&
                      (XW'(row_pos_ff) + XW'(1) + XW'(eff_f) > XW'(eff_rows));

   assign col_next = CNT_W'(col_pos_ff) + 1'b1;
   assign row_next = DIM_W'(row_pos_ff) + 1'b1;
   assign cib_next = EF_W'(cib_ff) + 1'b1;
   assign rib_next = EF_W'(rib_ff) + 1'b1;

   // Configuration registers and raster counters.
   always_comb begin
      factor_in  = factor_ff;
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      cib_in     = cib_ff;
      rib_in     = rib_ff;
      bcol_in    = bcol_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FACTOR: factor_in = csr_data[FACTOR_W-1:0];
            CSR_COLS:   cols_in   = csr_data;
            CSR_ROWS:   rows_in   = csr_data;
            default:    factor_in = factor_ff;
         endcase
      end
      if (restart) begin
         col_pos_in = '0;
         row_pos_in = '0;
         cib_in     = '0;
         rib_in     = '0;
         bcol_in    = '0;
      end else if (accept) begin
         if (cib_next >= eff_f) begin
            cib_in  = '0;
            bcol_in = bcol_ff + 1'b1;
         end else begin
            cib_in = cib_next[CIB_W-1:0];
         end
         if (col_next >= eff_cols) begin
            col_pos_in = '0;
            cib_in     = '0;
            bcol_in    = '0;
            row_pos_in = row_next[ROW_W-1:0];
            rib_in     = (rib_next >= eff_f) ? '0 : rib_next[CIB_W-1:0];
            if (row_next >= eff_rows) begin
               row_pos_in = '0;
               rib_in     = '0;
            end
         end else begin
            col_pos_in = col_next[COL_W-1:0];
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_block) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = last_ff ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid && in_block;
         end
         ST_ACCUM: begin
            cmd.accum     = 1'b1;
            cmd.first     = first_ff;
            cmd.div_start = last_ff;
         end
         ST_DIVIDE: begin
            cmd = '0;
         end
         ST_OUTPUT: begin
            cmd.out_load = status.out_free;
            cmd.out_last = img_ff;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         factor_ff  <= RST_FACTOR;
         cols_ff    <= RST_COLS;
         rows_ff    <= RST_ROWS;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
         bcol_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         factor_ff  <= factor_in;
         cols_ff    <= cols_in;
         rows_ff    <= rows_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         cib_ff     <= cib_in;
         rib_ff     <= rib_in;
         bcol_ff    <= bcol_in;
      end
   end

   // Hold the block flags of the item in flight.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         first_ff <= blk_first;
         last_ff  <= blk_last;
         img_ff   <= img_last;
      end
   end

   assign blk_addr   = bcol_ff;
   assign blk_factor = eff_f;

   `BAVG_ASSERT_NEXT(a_skip_stays_idle, state_ff == ST_IDLE && accept && !in_block, state_ff == ST_IDLE, "item outside a block left idle")
   `BAVG_ASSERT_SAME(a_divide_entry, state_ff == ST_DIVIDE, $past(state_ff) == ST_ACCUM || $past(state_ff) == ST_DIVIDE, "divide entered out of order")
   `BAVG_ASSERT_NEXT(a_div_launch, state_ff == ST_ACCUM && last_ff, status.div_busy, "divider not busy after block end")
   `BAVG_ASSERT_SAME(a_cib_range, 1'b1, EF_W'(cib_ff) < eff_f && EF_W'(rib_ff) < eff_f, "position in block out of range")

endmodule
`default_nettype wire

@@ rtl/bavg_dp.sv @@
`default_nettype none
module bavg_dp #(
   parameter int MAX_COLS   = bavg_pkg::DEF_MAX_COLS,
   parameter int MAX_FACTOR = bavg_pkg::DEF_MAX_FACTOR
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bavg_pkg::cmd_type                  cmd,
   output bavg_pkg::status_type                    status,
   input  wire logic [$clog2(MAX_COLS)-1:0]        blk_addr,
   input  wire logic [$clog2(MAX_FACTOR+1)-1:0]    blk_factor,
   input  wire logic [bavg_pkg::PIXEL_W-1:0]       req_pixel,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [bavg_pkg::PIXEL_W-1:0]            rsp_average,
   output logic                                    rsp_image_done
);
   import bavg_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int EF_W  = $clog2(MAX_FACTOR + 1);
   localparam int DV_W  = 2 * EF_W;
   localparam int SUM_W = PIXEL_W + 2 * $clog2(MAX_FACTOR);

   logic [SUM_W-1:0]   sum_mem [MAX_COLS];
   logic [PIXEL_W-1:0] pix_ff;
   logic [COL_W-1:0]   addr_ff;
   logic [SUM_W-1:0]   rd_ff;
   logic [SUM_W-1:0]   sum;
   logic [DV_W-1:0]    divisor;
   logic               div_busy;
   logic [SUM_W-1:0]   quotient;
   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_avg_ff;
   logic               out_done_ff;
   logic               out_free;

   assign sum     = cmd.first ? SUM_W'(pix_ff) : rd_ff + SUM_W'(pix_ff);
   assign divisor = DV_W'(blk_factor) * DV_W'(blk_factor);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff  <= req_pixel;
         addr_ff <= blk_addr;
         rd_ff   <= sum_mem[blk_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         sum_mem[addr_ff] <= sum;
      end
   end

   bavg_div #(
      .N_W (SUM_W),
      .D_W (DV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Output register: free when empty or being taken this cycle.
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_avg_ff  <= quotient[PIXEL_W-1:0];
         out_done_ff <= cmd.out_last;
      end
   end

   assign status.div_busy = div_busy;
   assign status.out_free = out_free;
   assign rsp_valid       = out_valid_ff;
   assign rsp_average     = out_avg_ff;
   assign rsp_image_done  = out_done_ff;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import bavg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES   = 48;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 800;
   localparam int DIRECTED_ROWS  = 37;

   typedef struct packed {
      logic [PIXEL_W-1:0] average;
      logic               image_done;
   } block_result_type;

   typedef struct packed {
      logic             typed;
      logic             has_result;
      block_result_type result;
   } pixel_plan_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_PIXEL,
      ROW_PIXEL_NONE,
      ROW_PIXEL_AVG
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [DIM_W-1:0]     data;
      logic [PIXEL_W-1:0]   pixel;
      logic [PIXEL_W-1:0]   average;
      logic                 image_done;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIXEL_W-1:0]   req_pixel = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]   rsp_average;
   logic                 rsp_image_done;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_data = '0;

   block_average_downscaler_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_average    (rsp_average),
      .rsp_image_done (rsp_image_done),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Downscaler state as the block should hold it
   logic [FACTOR_W-1:0] factor_reg;
   logic [DIM_W-1:0]    cols_reg;
   logic [DIM_W-1:0]    rows_reg;
   logic [15:0]         block_sums [0:DEF_MAX_COLS-1];
   logic [11:0]         col_pos;
   logic [11:0]         row_pos;
   logic [4:0]          col_in_blk;
   logic [4:0]          row_in_blk;
   logic [11:0]         blk_col;

   block_result_type pending_averages[$];
   pixel_plan_type   pixel_plans[$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   bit               calm = 1'b0;
   bit               hold_req = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'h00, 8'h00, 1'b0},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'hFF, 8'hFF, 1'b0},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'hAA, 8'hAA, 1'b0},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'h55, 8'h55, 1'b0},
      '{ROW_WRITE,      CSR_FACTOR, 12'd2,    8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_COLS,   12'd2,    8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_ROWS,   12'd2,    8'h00, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'hFF, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'hFF, 8'h00, 1'b0},
      // unknown index: no effect, image keeps going
      '{ROW_WRITE,      CSR_UNUSED, 12'hFFF,  8'h00, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'hFF, 8'h00, 1'b0},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'hFE, 8'hFE, 1'b1},
      '{ROW_PIXEL,      CSR_FACTOR, 12'd0,    8'h01, 8'h00, 1'b0},
      '{ROW_PIXEL,      CSR_FACTOR, 12'd0,    8'h02, 8'h00, 1'b0},
      '{ROW_PIXEL,      CSR_FACTOR, 12'd0,    8'h03, 8'h00, 1'b0},
      '{ROW_PIXEL,      CSR_FACTOR, 12'd0,    8'h04, 8'h00, 1'b0},
      // zero factor and zero sizes act as one
      '{ROW_WRITE,      CSR_FACTOR, 12'd0,    8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_COLS,   12'd0,    8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_ROWS,   12'd0,    8'h00, 8'h00, 1'b0},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'd77, 8'd77, 1'b1},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'h00, 8'h00, 1'b1},
      // oversized factor, bigger than the image: nothing comes out
      '{ROW_WRITE,      CSR_FACTOR, 12'd31,   8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_COLS,   12'd3,    8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_ROWS,   12'd3,    8'h00, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'd200, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'd200, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'd200, 8'h00, 1'b0},
      // oversized sizes saturate
      '{ROW_WRITE,      CSR_FACTOR, 12'd1,    8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_COLS,   12'hFFF,  8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_ROWS,   12'hFFF,  8'h00, 8'h00, 1'b0},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'hFF, 8'hFF, 1'b0},
      '{ROW_PIXEL_AVG,  CSR_FACTOR, 12'd0,    8'h01, 8'h01, 1'b0},
      '{ROW_WRITE,      CSR_FACTOR, 12'd16,   8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_COLS,   12'd2048, 8'h00, 8'h00, 1'b0},
      '{ROW_WRITE,      CSR_ROWS,   12'd2048, 8'h00, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'h09, 8'h00, 1'b0},
      '{ROW_PIXEL_NONE, CSR_FACTOR, 12'd0,    8'h09, 8'h00, 1'b0}
   };

   function automatic void restart_image();
      col_pos    = '0;
      row_pos    = '0;
      col_in_blk = '0;
      row_in_blk = '0;
      blk_col    = '0;
   endfunction

   function automatic void restore_defaults();
      factor_reg = RST_FACTOR;
      cols_reg   = RST_COLS;
      rows_reg   = RST_ROWS;
      for (int i = 0; i < DEF_MAX_COLS; i++) block_sums[i] = '0;
      restart_image();
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [DIM_W-1:0] val);
      case (idx)
         CSR_FACTOR: factor_reg = val[FACTOR_W-1:0];
         CSR_COLS:   cols_reg = val;
         CSR_ROWS:   rows_reg = val;
         default:    return;
      endcase
      restart_image();
   endfunction

   function automatic void predict_block_average(input logic [PIXEL_W-1:0] pix,
                                                 output bit hit,
                                                 output block_result_type res);
      int unsigned f;
      int unsigned cols;
      int unsigned rows;
      int unsigned full_bcols;
      int unsigned full_rows;
      f    = (factor_reg == 0) ? 1 : (factor_reg > DEF_MAX_FACTOR) ? DEF_MAX_FACTOR : factor_reg;
      cols = (cols_reg == 0) ? 1 : (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_reg;
      rows = (rows_reg == 0) ? 1 : (rows_reg > ROW_LIMIT) ? ROW_LIMIT : rows_reg;
      full_bcols = cols / f;
      full_rows  = (rows / f) * f;
      hit = 1'b0;
      res = '0;
      if (blk_col < full_bcols && row_pos < full_rows) begin
         if (row_in_blk == 0 && col_in_blk == 0) begin
            block_sums[blk_col] = 16'(pix);
         end else begin
            block_sums[blk_col] = block_sums[blk_col] + 16'(pix);
         end
         if (row_in_blk == f - 1 && col_in_blk == f - 1) begin
            hit = 1'b1;
            res.average    = 8'(block_sums[blk_col] / (f * f));
            res.image_done = (blk_col == full_bcols - 1) && (row_pos == full_rows - 1);
         end
      end
      // advance raster position, wrapping at line and image end
      col_pos    = col_pos + 1'b1;
      col_in_blk = col_in_blk + 1'b1;
      if (col_in_blk >= f) begin
         col_in_blk = '0;
         blk_col    = blk_col + 1'b1;
      end
      if (col_pos >= cols) begin
         col_pos    = '0;
         col_in_blk = '0;
         blk_col    = '0;
         row_pos    = row_pos + 1'b1;
         row_in_blk = row_in_blk + 1'b1;
         if (row_in_blk >= f) row_in_blk = '0;
         if (row_pos >= rows) begin
            row_pos    = '0;
            row_in_blk = '0;
         end
      end
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
   endfunction

   // Check results, then predict from inputs, all in one place per edge
   always @(posedge clock) begin : scoreboard
      block_result_type got;
      block_result_type want;
      pixel_plan_type   plan;
      bit               hit;
      block_result_type res;
      if (reset) begin
         restore_defaults();
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_average, rsp_image_done};
            if (pending_averages.size() == 0) begin
               note_mismatch($sformatf("unexpected item: average %0d image_done %0b",
                                       got.average, got.image_done));
            end else begin
               want = pending_averages.pop_front();
               if (got.average !== want.average || got.image_done !== want.image_done)
                  note_mismatch($sformatf(
                     "average exp %0d got %0d, image_done exp %0b got %0b",
                     want.average, got.average, want.image_done, got.image_done));
            end
         end
         if (csr_write) apply_register(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            plan = pixel_plans.pop_front();
            predict_block_average(req_pixel, hit, res);
            if (plan.typed) begin
               hit = plan.has_result;
               res = plan.result;
            end
            if (hit) pending_averages.push_back(res);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("block_average_downscaler_unit verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : result_sink
      int n;
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            n = pick_gap() + 1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input pixel_plan_type plan);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pixel_plans.push_back(plan);
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      req_valid <= 1'b0;
      // drain, then give items with no result time to leave the block
      do begin
         while (pending_averages.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end while (pending_averages.size() != 0);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin : stimulus
      stim_row_type       row;
      pixel_plan_type     plan;
      pixel_plan_type     free_plan;
      int                 sent;
      int                 fe;
      int                 ce;
      int                 re;
      int                 count;
      int                 fill;
      logic [DIM_W-1:0]   code;
      logic [PIXEL_W-1:0] pix;

      free_plan = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_WRITE: begin
               write_reg(row.reg_index, row.data);
            end
            default: begin
               plan.typed      = (row.kind != ROW_PIXEL);
               plan.has_result = (row.kind == ROW_PIXEL_AVG);
               plan.result     = '{row.average, row.image_done};
               send_pixel(row.pixel, plan);
            end
         endcase
      end

      // hold the result side off while pixels keep coming, so the block backs up
      write_reg(CSR_FACTOR, 12'd1);
      write_reg(CSR_COLS, 12'd8);
      write_reg(CSR_ROWS, 12'd8);
      calm = 1'b1;
      hold_req = 1'b1;
      for (int k = 0; k < 80; k++) send_pixel(8'($urandom_range(0, 255)), free_plan);
      calm = 1'b0;

      // largest block, all white: widest sum
      write_reg(CSR_FACTOR, 12'd16);
      write_reg(CSR_COLS, 12'd16);
      write_reg(CSR_ROWS, 12'd16);
      for (int k = 0; k < 256; k++) send_pixel(8'hFF, free_plan);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         fill = $urandom_range(0, 9);
         if (fill < 6) fe = $urandom_range(1, 4);
         else if (fill < 9) fe = $urandom_range(5, 15);
         else fe = 16;
         code = 12'(fe);
         if (fe == 1 && $urandom_range(0, 1) == 0) code = 12'd0;
         if (fe == 16 && $urandom_range(0, 1) == 0) code = 12'($urandom_range(17, 31));
         // upper data bits are not part of the factor
         code[DIM_W-1:FACTOR_W] = 7'($urandom_range(0, 127));
         write_reg(CSR_FACTOR, code);

         fill = $urandom_range(0, 19);
         if (fill == 0) begin
            ce = 1;
            code = 12'($urandom_range(0, 1));
         end else if (fill == 1) begin
            ce = DEF_MAX_COLS;
            code = ($urandom_range(0, 1) == 0) ? 12'd2048 : 12'($urandom_range(2049, 4095));
         end else begin
            ce = fe * $urandom_range(1, (fe >= 8) ? 1 : 4) + $urandom_range(0, fe - 1);
            code = 12'(ce);
         end
         write_reg(CSR_COLS, code);

         fill = $urandom_range(0, 19);
         if (fill == 0) begin
            re = 1;
            code = 12'($urandom_range(0, 1));
         end else if (fill == 1) begin
            re = ROW_LIMIT;
            code = ($urandom_range(0, 1) == 0) ? 12'd2048 : 12'($urandom_range(2049, 4095));
         end else begin
            re = fe * $urandom_range(1, (fe >= 8) ? 1 : 3) + $urandom_range(0, fe - 1);
            code = 12'(re);
         end
         write_reg(CSR_ROWS, code);

         if ($urandom_range(0, 9) == 0) write_reg(CSR_UNUSED, 12'($urandom_range(0, 4095)));

         count = ce * re * $urandom_range(1, 2) + $urandom_range(0, 3);
         if (count > 500) count = $urandom_range(30, 500);
         calm = ($urandom_range(0, 4) == 0);
         fill = $urandom_range(0, 9);
         for (int k = 0; k < count; k++) begin
            if (fill == 0) pix = 8'hFF;
            else if (fill == 1) pix = 8'h00;
            else pix = 8'($urandom_range(0, 255));
            send_pixel(pix, free_plan);
         end
         sent += count;
      end

      calm = 1'b0;
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_averages.size() == 0)
         $display("block_average_downscaler_unit verification clean");
      else
         $display("block_average_downscaler_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire
